### src/mxwp_pkg.sv
// shared types and constants of the event word parser
// used by the front, queue, back and checker; depends on nothing
package mxwp_pkg;

    // word type in bits 31..30
    localparam logic [1:0] TYPE_DATA   = 2'd0;
    localparam logic [1:0] TYPE_HEADER = 2'd1;
    localparam logic [1:0] TYPE_BAD    = 2'd2;
    localparam logic [1:0] TYPE_FOOTER = 2'd3;

    // subtype of a type-0 word, bits 29..22
    localparam logic [7:0] SUB_FILLER = 8'h00;
    localparam logic [7:0] SUB_DATA   = 8'h10;
    localparam logic [7:0] SUB_EXT_TS = 8'h12;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_TABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TDC_STYLE  = 2'd2;

    localparam int unsigned SLOT_W = 3;
    localparam int unsigned CHAN_W = 6;
    localparam int unsigned TS_W   = 46;
    localparam int unsigned LEN_W  = 12;

    typedef enum logic [2:0] {
        CLS_FILLER,
        CLS_HEADER,
        CLS_DATA,
        CLS_EXT_TS,
        CLS_FOOTER,
        CLS_ILLEGAL
    } t_cls;

    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_END     = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_UNKNOWN_MODULE = 3'd0,
        ST_NO_HEADER      = 3'd1,
        ST_BAD_CHANNEL    = 3'd2,
        ST_DUP_CHANNEL    = 3'd3,
        ST_ILLEGAL_WORD   = 3'd4
    } t_status;

    // classified word handed from front to back
    typedef struct packed {
        t_cls              cls;
        logic              slot_hit;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       word;
        logic              buf_last;
    } t_entry;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] module_res;
        logic [CHAN_W-1:0] channel;
        logic [31:0]       data_word;
        logic [31:0]       event_number;
        logic [TS_W-1:0]   timestamp;
        logic [LEN_W-1:0]  length;
        t_status           status;
        logic              last;
    } t_result;

endpackage

### src/mxwp_front.sv
// front part: classifies one readout word and looks up the header module slot
// depends on mxwp_pkg
module mxwp_front #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  logic [31:0]          i_word,
    input  logic                 i_buffer_last,
    input  logic [63:0]          i_id_table,
    input  logic [7:0]           i_enable_mask,
    output mxwp_pkg::t_entry     o_entry
);

    logic [1:0] w_type;
    logic [7:0] w_sub;
    logic [7:0] w_id;

    assign w_type = i_word[31:30];
    assign w_sub  = i_word[29:22];
    assign w_id   = i_word[23:16];

    // word classification and slot lookup
    always_comb begin
        o_entry.word     = i_word;
        o_entry.buf_last = i_buffer_last;
        unique case (w_type)
            mxwp_pkg::TYPE_HEADER: o_entry.cls = mxwp_pkg::CLS_HEADER;
            mxwp_pkg::TYPE_FOOTER: o_entry.cls = mxwp_pkg::CLS_FOOTER;
            mxwp_pkg::TYPE_DATA: begin
                priority if (w_sub == mxwp_pkg::SUB_FILLER)
                    o_entry.cls = mxwp_pkg::CLS_FILLER;
                else if (w_sub == mxwp_pkg::SUB_DATA)
                    o_entry.cls = mxwp_pkg::CLS_DATA;
                else if (w_sub == mxwp_pkg::SUB_EXT_TS)
                    o_entry.cls = mxwp_pkg::CLS_EXT_TS;
                else
                    o_entry.cls = mxwp_pkg::CLS_ILLEGAL;
            end
            default: o_entry.cls = mxwp_pkg::CLS_ILLEGAL;
        endcase

        // slot lookup, lowest enabled match wins
        o_entry.slot_hit = 1'b0;
        o_entry.slot     = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (i_enable_mask[k] && (i_id_table[8*k +: 8] == w_id)) begin
                o_entry.slot_hit = 1'b1;
                o_entry.slot     = mxwp_pkg::SLOT_W'(k);
            end
        end
    end

endmodule

### src/mxwp_queue.sv
// two-entry queue of classified words between front and back
// depends on mxwp_pkg
module mxwp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mxwp_pkg::t_entry    i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output mxwp_pkg::t_entry    o_entry
);

    mxwp_pkg::t_entry r_slots [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_slots[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push)
                r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)
                r_rd_ptr <= ~r_rd_ptr;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_slots[r_wr_ptr] <= i_entry;
    end

endmodule

### src/mxwp_back.sv
// back part: event state, channel store and result generation
// depends on mxwp_pkg
module mxwp_back #(
    parameter int unsigned NUM_SLOTS    = 8,
    parameter int unsigned NUM_CHANNELS = 34
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  mxwp_pkg::t_entry    i_q_entry,
    output logic                o_q_pop,
    input  logic [7:0]          i_tdc_mask,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output mxwp_pkg::t_result   o_out
);

    localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int unsigned IDX_W = $clog2(NUM_CHANNELS + 1);
    localparam int unsigned SL_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                      r_state;
    logic                        r_out_valid;
    mxwp_pkg::t_result           r_out;
    logic                        r_open;
    logic                        r_aborted;
    logic [mxwp_pkg::SLOT_W-1:0] r_slot;
    logic [31:0]                 r_header;
    logic [15:0]                 r_ext_ts;
    logic                        r_ext_valid;
    logic [31:0]                 r_counts [NUM_SLOTS];
    logic [31:0]                 r_cur_count;
    logic [NUM_CHANNELS-1:0]     r_filled;
    logic [mxwp_pkg::TS_W-1:0]   r_ts;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_end_last;
    logic [31:0]                 r_store [NUM_CHANNELS];
    logic [31:0]                 r_rd_data;

    logic                        w_out_free;
    logic                        w_pop;
    logic [mxwp_pkg::CHAN_W-1:0] w_chan;
    logic [CH_W-1:0]             w_chan_ix;
    logic [SL_W-1:0]             w_slot_ix;
    logic                        w_store_wr;
    logic [mxwp_pkg::TS_W-1:0]   w_ts;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_pop       = (r_state == S_IDLE) && i_q_valid && w_out_free;
    assign o_q_pop     = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_chan      = i_q_entry.word[21:16];
    assign w_chan_ix   = w_chan[CH_W-1:0];
    assign w_slot_ix   = i_q_entry.slot[SL_W-1:0];
    assign w_ts        = {(r_ext_valid ? r_ext_ts : 16'h0000), i_q_entry.word[29:0]};

    // a data word that is stored rather than reported
    assign w_store_wr = w_pop && !r_aborted && r_open
                        && (i_q_entry.cls == mxwp_pkg::CLS_DATA)
                        && (32'(w_chan) < NUM_CHANNELS)
                        && !(i_tdc_mask[r_slot] && r_filled[w_chan_ix]);

    // result with the context of the open event
    function automatic mxwp_pkg::t_result mk_res(
        input mxwp_pkg::t_kind           kind,
        input logic [mxwp_pkg::CHAN_W-1:0] chan,
        input logic [31:0]               dw,
        input logic [mxwp_pkg::TS_W-1:0] ts,
        input mxwp_pkg::t_status         st,
        input logic                      last,
        input logic                      open,
        input logic [mxwp_pkg::SLOT_W-1:0] slot,
        input logic [31:0]               cnt,
        input logic [31:0]               hdr
    );
        mxwp_pkg::t_result res;
        res.kind         = kind;
        res.module_res   = open ? slot : '0;
        res.channel      = chan;
        res.data_word    = dw;
        res.event_number = open ? cnt : 32'h0;
        res.timestamp    = ts;
        res.length       = open ? hdr[mxwp_pkg::LEN_W-1:0] : '0;
        res.status       = st;
        res.last         = last;
        return res;
    endfunction

    // channel store, written by data words, read during a footer drain
    always_ff @(posedge i_clk) begin
        if (w_store_wr)
            r_store[w_chan_ix] <= i_q_entry.word;
        r_rd_data <= r_store[r_idx[CH_W-1:0]];
    end

    // event state machine and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_open      <= 1'b0;
            r_aborted   <= 1'b0;
            r_slot      <= '0;
            r_header    <= 32'h0;
            r_ext_ts    <= 16'h0;
            r_ext_valid <= 1'b0;
            r_cur_count <= 32'h0;
            r_filled    <= '0;
            r_idx       <= '0;
            r_end_last  <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++)
                r_counts[k] <= 32'h0;
        end else begin
            if (i_out_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        if (!r_aborted) begin
                            unique case (i_q_entry.cls)
                                mxwp_pkg::CLS_HEADER: begin
                                    if (!i_q_entry.slot_hit) begin
                                        r_out_valid <= 1'b1;
                                        r_out <= mk_res(mxwp_pkg::KIND_STATUS, '0,
                                            i_q_entry.word, '0,
                                            mxwp_pkg::ST_UNKNOWN_MODULE, 1'b1,
                                            r_open, r_slot, r_cur_count, r_header);
                                        r_aborted <= 1'b1;
                                    end else begin
                                        r_filled    <= '0;
                                        r_ext_valid <= 1'b0;
                                        r_open      <= 1'b1;
                                        r_slot      <= i_q_entry.slot;
                                        r_header    <= i_q_entry.word;
                                        r_counts[w_slot_ix] <= r_counts[w_slot_ix] + 32'd1;
                                        r_cur_count <= r_counts[w_slot_ix] + 32'd1;
                                    end
                                end
                                mxwp_pkg::CLS_DATA: begin
                                    priority if (!r_open) begin
                                        r_out_valid <= 1'b1;
                                        r_out <= mk_res(mxwp_pkg::KIND_STATUS, '0,
                                            i_q_entry.word, '0,
                                            mxwp_pkg::ST_NO_HEADER, 1'b1,
                                            r_open, r_slot, r_cur_count, r_header);
                                        r_aborted <= 1'b1;
                                    end else if (32'(w_chan) >= NUM_CHANNELS) begin
                                        r_out_valid <= 1'b1;
                                        r_out <= mk_res(mxwp_pkg::KIND_STATUS, w_chan,
                                            i_q_entry.word, '0,
                                            mxwp_pkg::ST_BAD_CHANNEL, 1'b1,
                                            r_open, r_slot, r_cur_count, r_header);
                                        r_aborted <= 1'b1;
                                    end else if (i_tdc_mask[r_slot]
                                                 && r_filled[w_chan_ix]) begin
                                        r_out_valid <= 1'b1;
                                        r_out <= mk_res(mxwp_pkg::KIND_STATUS, w_chan,
                                            i_q_entry.word, '0,
                                            mxwp_pkg::ST_DUP_CHANNEL, 1'b1,
                                            r_open, r_slot, r_cur_count, r_header);
                                    end else begin
                                        r_filled[w_chan_ix] <= 1'b1;
                                    end
                                end
                                mxwp_pkg::CLS_EXT_TS: begin
                                    if (!r_open) begin
                                        r_out_valid <= 1'b1;
                                        r_out <= mk_res(mxwp_pkg::KIND_STATUS, '0,
                                            i_q_entry.word, '0,
                                            mxwp_pkg::ST_NO_HEADER, 1'b1,
                                            r_open, r_slot, r_cur_count, r_header);
                                        r_aborted <= 1'b1;
                                    end else begin
                                        r_ext_ts    <= i_q_entry.word[15:0];
                                        r_ext_valid <= 1'b1;
                                    end
                                end
                                mxwp_pkg::CLS_FOOTER: begin
                                    if (!r_open) begin
                                        r_out_valid <= 1'b1;
                                        r_out <= mk_res(mxwp_pkg::KIND_STATUS, '0,
                                            i_q_entry.word, '0,
                                            mxwp_pkg::ST_NO_HEADER, 1'b1,
                                            r_open, r_slot, r_cur_count, r_header);
                                        r_aborted <= 1'b1;
                                    end else begin
                                        r_ts       <= w_ts;
                                        r_idx      <= '0;
                                        r_end_last <= i_q_entry.buf_last;
                                        r_state    <= S_SCAN;
                                    end
                                end
                                mxwp_pkg::CLS_ILLEGAL: begin
                                    r_out_valid <= 1'b1;
                                    r_out <= mk_res(mxwp_pkg::KIND_STATUS, '0,
                                        i_q_entry.word, '0,
                                        mxwp_pkg::ST_ILLEGAL_WORD, 1'b1,
                                        r_open, r_slot, r_cur_count, r_header);
                                end
                                default: begin
                                    // filler word
                                end
                            endcase
                        end
                        // buffer end, unless a drain is starting and will do it
                        if (i_q_entry.buf_last && !(!r_aborted && r_open
                                && (i_q_entry.cls == mxwp_pkg::CLS_FOOTER))) begin
                            r_filled    <= '0;
                            r_ext_valid <= 1'b0;
                            r_open      <= 1'b0;
                            r_aborted   <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    if (32'(r_idx) == NUM_CHANNELS) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out <= mk_res(mxwp_pkg::KIND_END, '0, r_header, r_ts,
                                mxwp_pkg::ST_UNKNOWN_MODULE, 1'b1,
                                r_open, r_slot, r_cur_count, r_header);
                            r_filled    <= '0;
                            r_ext_valid <= 1'b0;
                            r_open      <= 1'b0;
                            if (r_end_last)
                                r_aborted <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else if (r_filled[r_idx[CH_W-1:0]]) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= mk_res(mxwp_pkg::KIND_CHANNEL,
                            mxwp_pkg::CHAN_W'(r_idx), r_rd_data, r_ts,
                            mxwp_pkg::ST_UNKNOWN_MODULE, 1'b0,
                            r_open, r_slot, r_cur_count, r_header);
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### src/mxdc32_event_word_parser.sv
// readout word parser: a word passes the input queue and then reaches the result
// register; one word per cycle for words with no result or one result, while
// the result output is not stalled. A footer holds the back part while it scans
// every channel in turn, emitting a result for each filled channel, then the
// event end. Synchronous active-low reset clears event state, event counts and
// configuration; the channel store holds no reset.
// depends on mxwp_pkg, mxwp_front, mxwp_queue, mxwp_back
module mxdc32_event_word_parser #(
    parameter int unsigned NUM_SLOTS    = 8,
    parameter int unsigned NUM_CHANNELS = 34
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // word input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [31:0]                       i_word,
    input  logic                              i_buffer_last,
    // result output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_kind,
    output logic [mxwp_pkg::SLOT_W-1:0]       o_module_res,
    output logic [mxwp_pkg::CHAN_W-1:0]       o_channel,
    output logic [31:0]                       o_data_word,
    output logic [31:0]                       o_event_number,
    output logic [mxwp_pkg::TS_W-1:0]         o_timestamp,
    output logic [mxwp_pkg::LEN_W-1:0]        o_length,
    output logic [2:0]                        o_status,
    output logic                              o_last,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mxwp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);

    logic [63:0]       r_id_table;
    logic [7:0]        r_enable_mask;
    logic [7:0]        r_tdc_mask;

    mxwp_pkg::t_entry  w_front_entry;
    mxwp_pkg::t_entry  w_q_entry;
    mxwp_pkg::t_result w_res;
    logic              w_q_full;
    logic              w_q_valid;
    logic              w_q_pop;
    logic              w_push;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !w_q_full;
    assign w_push      = i_valid && !w_q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_table    <= 64'h0;
            r_enable_mask <= 8'h00;
            r_tdc_mask    <= 8'h00;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mxwp_pkg::CFG_ID_TABLE:  r_id_table    <= i_cfg_data;
                mxwp_pkg::CFG_ENABLE:    r_enable_mask <= i_cfg_data[7:0];
                mxwp_pkg::CFG_TDC_STYLE: r_tdc_mask    <= i_cfg_data[7:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    mxwp_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_word        (i_word),
        .i_buffer_last (i_buffer_last),
        .i_id_table    (r_id_table),
        .i_enable_mask (r_enable_mask),
        .o_entry       (w_front_entry)
    );

    mxwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    mxwp_back #(
        .NUM_SLOTS    (NUM_SLOTS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_q_pop),
        .i_tdc_mask  (r_tdc_mask),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_out       (w_res)
    );

    // result fields to ports
    assign o_kind         = w_res.kind;
    assign o_module_res   = w_res.module_res;
    assign o_channel      = w_res.channel;
    assign o_data_word    = w_res.data_word;
    assign o_event_number = w_res.event_number;
    assign o_timestamp    = w_res.timestamp;
    assign o_length       = w_res.length;
    assign o_status       = (w_res.kind == mxwp_pkg::KIND_STATUS) ? w_res.status : 3'd0;
    assign o_last         = w_res.last;

endmodule

### src/mxwp_checker.sv
// port-level checks of the event word parser, bound to the top level
// depends on mxwp_pkg and mxdc32_event_word_parser
module mxwp_checker #(
    parameter int unsigned NUM_CHANNELS = 34
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [1:0]                   o_kind,
    input logic [mxwp_pkg::CHAN_W-1:0]  o_channel,
    input logic [31:0]                  o_data_word,
    input logic [mxwp_pkg::TS_W-1:0]    o_timestamp,
    input logic [2:0]                   o_status,
    input logic                         o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_word) && $stable(o_kind))
        else $error("result changed while stalled");

    // channel results are never final and point into the store
    a_chan_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == mxwp_pkg::KIND_CHANNEL) |->
            !o_last && (o_status == 3'd0) && (32'(o_channel) < NUM_CHANNELS))
        else $error("bad channel result");

    // event end closes the footer's results
    a_end_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == mxwp_pkg::KIND_END) |-> o_last && (o_channel == '0))
        else $error("bad event end result");

    // status results carry no timestamp and are final
    a_status_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == mxwp_pkg::KIND_STATUS) |->
            o_last && (o_timestamp == '0))
        else $error("bad status result");

endmodule

bind mxdc32_event_word_parser mxwp_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_kind      (o_kind),
    .o_channel   (o_channel),
    .o_data_word (o_data_word),
    .o_timestamp (o_timestamp),
    .o_status    (o_status),
    .o_last      (o_last)
);
